// ----- rtl/mwbb_pkg.sv -----
package mwbb_pkg;

    localparam int CFG_W_BITS    = 11;
    localparam int CFG_H_BITS    = 13;
    localparam int CFG_R_BITS    = 3;
    localparam int CFG_F_BITS    = 9;
    localparam int CFG_DATA_BITS = 13;
    localparam int CFG_IDX_BITS  = 2;

    localparam int MAX_HEIGHT   = 4096;
    localparam int WEIGHT_ONE   = 256;
    localparam int WEIGHT_SHIFT = 8;

    localparam logic [CFG_W_BITS-1:0] RST_WIDTH  = 11'd256;
    localparam logic [CFG_H_BITS-1:0] RST_HEIGHT = 13'd256;
    localparam logic [CFG_R_BITS-1:0] RST_RADIUS = 3'd4;
    localparam logic [CFG_F_BITS-1:0] RST_WEIGHT = 9'd205;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_RADIUS = 2'd2,
        REG_WEIGHT = 2'd3
    } t_reg_idx;

endpackage

// ----- rtl/mwbb_in_if.sv -----
interface mwbb_in_if #(
    parameter int PIXEL_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel_value;
    logic                         hot_flag;
    logic                         flush_tick;

    modport source (output valid, pixel_value, hot_flag, flush_tick, input ready);
    modport sink   (input valid, pixel_value, hot_flag, flush_tick, output ready);
endinterface

// ----- rtl/mwbb_out_if.sv -----
interface mwbb_out_if #(
    parameter int PIXEL_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] blurred_value;
    logic                         last_pixel;

    modport source (output valid, blurred_value, last_pixel, input ready);
    modport sink   (input valid, blurred_value, last_pixel, output ready);
endinterface

// ----- rtl/mwbb_ram.sv -----
module mwbb_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/masked_weighted_box_blur.sv -----
// Masked weighted box blur. Pixels enter in raster order and are written
// into a circular line store (one synchronous RAM, a power of two deep, at
// least 2*MAX_RADIUS*MAX_WIDTH+2*MAX_RADIUS+1 words) as they are taken in. When
// the pixel R rows and R columns ahead of the next pending result has been
// taken in, the block walks that result's clipped window, one store read a
// cycle, then forms the weighted numerator and the denominator, and runs a
// restoring divider that retires one quotient bit a cycle; an empty window
// skips the divider. The input stays blocked while a result is computed,
// and in the cycle after a register write. A finished result waits in the
// output register while the next word is taken in. After the last pixel of
// the frame, filler words (flush_tick) release the remaining results; the
// final result carries last_pixel. Any register write restarts the frame.
// The store needs no clearing after reset.
module masked_weighted_box_blur
    import mwbb_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 7,
    parameter int PIXEL_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    mwbb_in_if.sink                  i_in,
    mwbb_out_if.source               o_out
);
    localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int DEPTH = 1 << $clog2(2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int WIN   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int CNTW  = $clog2(WIN + 1);
    localparam int SUMW  = PIXEL_BITS + CNTW;
    localparam int NUMW  = SUMW + CFG_F_BITS + 2;
    localparam int DENW  = CNTW + CFG_F_BITS;
    localparam int DVW   = DENW + 1;
    localparam int QW    = NUMW + 1;
    localparam int ITW   = $clog2(QW + 1);

    localparam logic [QW-1:0] Q_PMAX     = QW'((64'd1 << (PIXEL_BITS - 1)) - 64'd1);
    localparam logic [QW-1:0] Q_PMIN_MAG = QW'(64'd1 << (PIXEL_BITS - 1));
    localparam logic [PIXEL_BITS-1:0] PIX_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};
    localparam logic [PIXEL_BITS-1:0] PIX_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_SCAN, S_DRAIN, S_MUL_NUM, S_MUL_DEN, S_PREP, S_DIV, S_OUT
    } t_state;

    t_state r_state;

    logic [CFG_W_BITS-1:0] r_cfg_w;
    logic [CFG_H_BITS-1:0] r_cfg_h;
    logic [CFG_R_BITS-1:0] r_cfg_r;
    logic [CFG_F_BITS-1:0] r_cfg_f;
    logic                  r_cfg_settle;

    logic [CFG_W_BITS-1:0] w_eff;
    logic [CFG_H_BITS-1:0] h_eff;
    logic [CFG_R_BITS-1:0] r_eff;
    logic [CFG_F_BITS-1:0] f_eff;

    logic [PW-1:0] r_total;
    logic [PW-1:0] r_lag;

    logic [PW-1:0]         r_in_pos;
    logic                  r_in_done;
    logic [PW-1:0]         r_out_pos;
    logic [CFG_H_BITS-1:0] r_out_row;
    logic [CFG_W_BITS-1:0] r_out_col;

    // window walk
    logic [CFG_H_BITS-1:0] r_k, r_k1;
    logic [CFG_W_BITS-1:0] r_l, r_l0, r_l1;
    logic [PW-1:0]         r_row_base;
    logic                  r_rd_valid, r_rd_centre;

    logic signed [SUMW-1:0]       r_sum;
    logic signed [PIXEL_BITS-1:0] r_ctr;
    logic [CNTW-1:0]              r_cnt;
    logic signed [NUMW-1:0]       r_num;
    logic [DENW-1:0]              r_den;
    logic                         r_neg;
    logic [QW-1:0]                r_quo;
    logic [DVW-1:0]               r_rem;
    logic [ITW-1:0]               r_it;

    logic                  r_out_valid;
    logic [PIXEL_BITS-1:0] r_out_value;
    logic                  r_out_last;

    // effective register values
    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = CFG_W_BITS'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w_eff = CFG_W_BITS'(MAX_WIDTH);
        end else begin
            w_eff = r_cfg_w;
        end
        if (r_cfg_h == '0) begin
            h_eff = CFG_H_BITS'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            h_eff = CFG_H_BITS'(MAX_HEIGHT);
        end else begin
            h_eff = r_cfg_h;
        end
        r_eff = (32'(r_cfg_r) > MAX_RADIUS) ? CFG_R_BITS'(MAX_RADIUS) : r_cfg_r;
        f_eff = (32'(r_cfg_f) > WEIGHT_ONE) ? CFG_F_BITS'(WEIGHT_ONE) : r_cfg_f;
    end

    logic accept, flush, wr_en;
    logic [PW-1:0] written, need;
    logic [PW:0]   need_raw;
    logic          emit;

    assign accept = i_in.valid && i_in.ready;
    assign flush  = i_in.flush_tick;
    assign wr_en  = accept && !r_in_done && !flush;

    always_comb begin
        written  = r_in_done ? r_total : r_in_pos + PW'(1);
        need_raw = {1'b0, r_out_pos} + {1'b0, r_lag} + (PW+1)'(1);
        need     = (need_raw > {1'b0, r_total}) ? r_total : need_raw[PW-1:0];
        emit     = (r_in_done || !flush) && (written >= need);
    end

    // window bounds from the pending output position
    logic [CFG_H_BITS-1:0] k0, k1;
    logic [CFG_W_BITS-1:0] l0, l1;
    logic [CFG_H_BITS:0]   k_hi;
    logic [CFG_W_BITS:0]   l_hi;

    always_comb begin
        k0   = (r_out_row > CFG_H_BITS'(r_eff)) ? r_out_row - CFG_H_BITS'(r_eff) : '0;
        l0   = (r_out_col > CFG_W_BITS'(r_eff)) ? r_out_col - CFG_W_BITS'(r_eff) : '0;
        k_hi = {1'b0, r_out_row} + (CFG_H_BITS+1)'(r_eff);
        l_hi = {1'b0, r_out_col} + (CFG_W_BITS+1)'(r_eff);
        k1   = (k_hi < {1'b0, h_eff}) ? k_hi[CFG_H_BITS-1:0] : h_eff - CFG_H_BITS'(1);
        l1   = (l_hi < {1'b0, w_eff}) ? l_hi[CFG_W_BITS-1:0] : w_eff - CFG_W_BITS'(1);
    end

    // line store
    logic [PW-1:0]         rd_lin;
    logic [PIXEL_BITS:0]   ram_q;
    logic                  rd_hot;
    logic signed [PIXEL_BITS-1:0] rd_val;

    assign rd_lin = r_row_base + PW'(r_l);
    assign rd_hot = ram_q[PIXEL_BITS];
    assign rd_val = $signed(ram_q[PIXEL_BITS-1:0]);

    mwbb_ram #(
        .WIDTH (PIXEL_BITS + 1),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_in_pos[AW-1:0]),
        .i_wdata ({i_in.hot_flag, i_in.pixel_value}),
        .i_raddr (rd_lin[AW-1:0]),
        .o_rdata (ram_q)
    );

    // divider step
    logic [DVW-1:0] divisor;
    logic [DVW:0]   trial;
    logic           ge;
    logic [DVW-1:0] n_rem;

    always_comb begin
        divisor = {r_den, 1'b0};
        trial   = {r_rem, r_quo[QW-1]};
        ge      = trial >= {1'b0, divisor};
        n_rem   = ge ? DVW'(trial - {1'b0, divisor}) : trial[DVW-1:0];
    end

    logic signed [NUMW-1:0] n_num;
    logic [DENW-1:0]        n_den;
    logic [NUMW-1:0]        mag;
    logic [PIXEL_BITS-1:0]  sat;
    logic                   out_last;
    logic                   out_free;

    always_comb begin
        n_num = (NUMW'(r_ctr) <<< WEIGHT_SHIFT)
              + NUMW'(r_sum) * NUMW'($signed({1'b0, f_eff}));
        n_den = DENW'(WEIGHT_ONE) + DENW'(r_cnt - CNTW'(1)) * DENW'(f_eff);
        mag   = r_num[NUMW-1] ? NUMW'(-r_num) : NUMW'(r_num);
        if (r_neg) begin
            sat = (r_quo > Q_PMIN_MAG) ? PIX_MIN : PIXEL_BITS'(-r_quo[PIXEL_BITS-1:0]);
        end else begin
            sat = (r_quo > Q_PMAX) ? PIX_MAX : r_quo[PIXEL_BITS-1:0];
        end
        out_last = (r_out_pos + PW'(1)) >= r_total;
        out_free = !r_out_valid || o_out.ready;
    end

    always_ff @(posedge i_clk) begin
        r_total <= PW'(w_eff) * PW'(h_eff);
        r_lag   <= PW'(r_eff) * PW'(w_eff) + PW'(r_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_w      <= RST_WIDTH;
            r_cfg_h      <= RST_HEIGHT;
            r_cfg_r      <= RST_RADIUS;
            r_cfg_f      <= RST_WEIGHT;
            r_cfg_settle <= 1'b1;
            r_in_pos     <= '0;
            r_in_done    <= 1'b0;
            r_out_pos    <= '0;
            r_out_row    <= '0;
            r_out_col    <= '0;
            r_rd_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_it         <= '0;
        end else begin
            // hold the input while frame size and lag follow a register write
            r_cfg_settle <= i_cfg_we;

            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (r_rd_valid && !rd_hot) begin
                r_cnt <= r_cnt + CNTW'(1);
                if (r_rd_centre) begin
                    r_ctr <= rd_val;
                end else begin
                    r_sum <= r_sum + SUMW'(rd_val);
                end
            end
            r_rd_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (wr_en) begin
                            r_in_pos <= r_in_pos + PW'(1);
                            if (r_in_pos + PW'(1) >= r_total) begin
                                r_in_done <= 1'b1;
                            end
                        end
                        if (emit) begin
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_k        <= k0;
                    r_k1       <= k1;
                    r_l        <= l0;
                    r_l0       <= l0;
                    r_l1       <= l1;
                    r_row_base <= PW'(k0) * PW'(w_eff);
                    r_sum      <= '0;
                    r_ctr      <= '0;
                    r_cnt      <= '0;
                    r_state    <= S_SCAN;
                end
                S_SCAN: begin
                    // issue one store read per cycle
                    r_rd_valid  <= 1'b1;
                    r_rd_centre <= (r_k == r_out_row) && (r_l == r_out_col);
                    if (r_l == r_l1) begin
                        if (r_k == r_k1) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_k        <= r_k + CFG_H_BITS'(1);
                            r_row_base <= r_row_base + PW'(w_eff);
                            r_l        <= r_l0;
                        end
                    end else begin
                        r_l <= r_l + CFG_W_BITS'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_MUL_NUM;
                end
                S_MUL_NUM: begin
                    r_num   <= n_num;
                    r_state <= S_MUL_DEN;
                end
                S_MUL_DEN: begin
                    r_den <= n_den;
                    if (r_cnt == '0) begin
                        r_quo   <= '0;
                        r_neg   <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_neg   <= r_num[NUMW-1];
                        r_quo   <= QW'(mag);
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    // round to nearest: (2|num| + den) / (2 den)
                    r_quo   <= {r_quo[QW-2:0], 1'b0} + QW'(r_den);
                    r_rem   <= '0;
                    r_it    <= ITW'(QW);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[QW-2:0], ge};
                    r_it  <= r_it - ITW'(1);
                    if (r_it == ITW'(1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= sat;
                        r_out_last  <= out_last;
                        if (out_last) begin
                            r_in_pos  <= '0;
                            r_in_done <= 1'b0;
                            r_out_pos <= '0;
                            r_out_row <= '0;
                            r_out_col <= '0;
                        end else begin
                            r_out_pos <= r_out_pos + PW'(1);
                            if (r_out_col + CFG_W_BITS'(1) >= w_eff) begin
                                r_out_col <= '0;
                                r_out_row <= r_out_row + CFG_H_BITS'(1);
                            end else begin
                                r_out_col <= r_out_col + CFG_W_BITS'(1);
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_WIDTH:  r_cfg_w <= i_cfg_data[CFG_W_BITS-1:0];
                    REG_HEIGHT: r_cfg_h <= i_cfg_data[CFG_H_BITS-1:0];
                    REG_RADIUS: r_cfg_r <= i_cfg_data[CFG_R_BITS-1:0];
                    REG_WEIGHT: r_cfg_f <= i_cfg_data[CFG_F_BITS-1:0];
                    default:    r_cfg_w <= r_cfg_w;
                endcase
                // restart the frame
                r_in_pos  <= '0;
                r_in_done <= 1'b0;
                r_out_pos <= '0;
                r_out_row <= '0;
                r_out_col <= '0;
            end
        end
    end

    assign i_in.ready          = (r_state == S_IDLE) && !r_cfg_settle;
    assign o_out.valid         = r_out_valid;
    assign o_out.blurred_value = r_out_value;
    assign o_out.last_pixel    = r_out_last;

    a_rd_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("store read data outside window walk");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_it == ITW'(1)) |=> (r_state == S_OUT))
        else $error("divider did not finish");

    a_out_behind_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_in_done) |-> (r_out_pos < r_in_pos))
        else $error("result ahead of written pixels");
endmodule

// ----- test/masked_weighted_box_blur_tb.sv -----
module masked_weighted_box_blur_tb;
    import mwbb_pkg::*;

    localparam int PIX_BITS    = 16;
    localparam int LIM_WIDTH   = 1024;
    localparam int LIM_RADIUS  = 7;
    localparam int STORE_DEPTH = 2 * LIM_RADIUS * LIM_WIDTH + 2 * LIM_RADIUS + 1;
    localparam int DRAIN_WAIT  = 400;

    typedef struct packed {
        logic signed [PIX_BITS-1:0] val;
        logic                       last;
    } t_blur_res;

    typedef struct {
        bit is_cfg;
        int a;
        int b;
        int c;
        int d;
        bit has_exp;
        int exp_val;
        bit exp_last;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    mwbb_in_if  #(.PIXEL_BITS(PIX_BITS)) in_if ();
    mwbb_out_if #(.PIXEL_BITS(PIX_BITS)) out_if ();

    masked_weighted_box_blur #(
        .MAX_WIDTH (LIM_WIDTH),
        .MAX_RADIUS(LIM_RADIUS),
        .PIXEL_BITS(PIX_BITS)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_if),
        .o_out     (out_if)
    );

    // predictor state
    logic signed [PIX_BITS-1:0] st_val [STORE_DEPTH];
    bit                         st_hot [STORE_DEPTH];
    logic [CFG_W_BITS-1:0] cfg_w;
    logic [CFG_H_BITS-1:0] cfg_h;
    logic [CFG_R_BITS-1:0] cfg_r;
    logic [CFG_F_BITS-1:0] cfg_f;
    int unsigned in_col, in_row, out_col, out_row;
    bit          in_done;

    t_blur_res blurred_q[$];
    int        n_errors;
    int        n_sent;
    int        hold_cycles;
    bit        calm;

    t_dir_row dir_tab [0:24];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        n_errors++;
    endtask

    function automatic int unsigned eff_w();
        if (cfg_w == 0) return 1;
        return (cfg_w > LIM_WIDTH) ? LIM_WIDTH : cfg_w;
    endfunction

    function automatic int unsigned eff_h();
        if (cfg_h == 0) return 1;
        return (cfg_h > MAX_HEIGHT) ? MAX_HEIGHT : cfg_h;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 24) == 0) return $urandom_range(20, 80);
        return $urandom_range(1, 4);
    endfunction

    function automatic logic signed [PIX_BITS-1:0] window_mean(
        input int unsigned row, input int unsigned col, input int unsigned w,
        input int unsigned h, input int unsigned r, input int unsigned f);
        longint num, den, mag, q;
        int unsigned cnt, idx, k0, k1, l0, l1;
        num = 0;
        cnt = 0;
        k0 = (row > r) ? row - r : 0;
        k1 = (row + r < h) ? row + r : h - 1;
        l0 = (col > r) ? col - r : 0;
        l1 = (col + r < w) ? col + r : w - 1;
        for (int unsigned k = k0; k <= k1; k++) begin
            for (int unsigned l = l0; l <= l1; l++) begin
                idx = (k * w + l) % STORE_DEPTH;
                if (!st_hot[idx]) begin
                    cnt++;
                    if (k == row && l == col) num += longint'(st_val[idx]) * WEIGHT_ONE;
                    else num += longint'(st_val[idx]) * longint'(f);
                end
            end
        end
        if (cnt == 0) return '0;
        den = WEIGHT_ONE + longint'(cnt - 1) * longint'(f);
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        if (num < 0) q = -q;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[PIX_BITS-1:0];
    endfunction

    task automatic predict_word(input logic signed [PIX_BITS-1:0] px, input bit hot,
                                input bit flush);
        int unsigned w, h, r, f, total, lag, written, qpos, need, pos;
        t_blur_res res;
        w = eff_w();
        h = eff_h();
        r = (cfg_r > LIM_RADIUS) ? LIM_RADIUS : cfg_r;
        f = (cfg_f > WEIGHT_ONE) ? WEIGHT_ONE : cfg_f;
        total = w * h;
        lag = r * w + r;
        if (!in_done) begin
            if (flush) return;
            if (in_col >= w) in_col = w - 1;
            if (in_row >= h) in_row = h - 1;
            pos = in_row * w + in_col;
            st_val[pos % STORE_DEPTH] = px;
            st_hot[pos % STORE_DEPTH] = hot;
            if (pos + 1 >= total) in_done = 1'b1;
            else if (in_col + 1 >= w) begin
                in_col = 0;
                in_row++;
            end else in_col++;
            written = pos + 1;
        end else written = total;
        if (out_col >= w) out_col = w - 1;
        if (out_row >= h) out_row = h - 1;
        qpos = out_row * w + out_col;
        need = qpos + lag + 1;
        if (need > total) need = total;
        if (written < need) return;
        res.val = window_mean(out_row, out_col, w, h, r, f);
        res.last = (qpos + 1 >= total);
        blurred_q.push_back(res);
        if (qpos + 1 >= total) begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0; in_done = 1'b0;
        end else if (out_col + 1 >= w) begin
            out_col = 0;
            out_row++;
        end else out_col++;
    endtask

    task automatic send_word(input logic signed [PIX_BITS-1:0] px, input bit hot,
                             input bit flush);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.pixel_value <= px;
        in_if.hot_flag    <= hot;
        in_if.flush_tick  <= flush;
        do @(posedge i_clk); while (!in_if.ready);
        predict_word(px, hot, flush);
        n_sent++;
    endtask

    // drop valid, let every pending result drain, then give the block time to settle
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (blurred_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic load_regs(input bit [3:0] sel, input int w, input int h, input int r,
                             input int f);
        logic [CFG_DATA_BITS-1:0] v [4];
        v[0] = CFG_DATA_BITS'(w);
        v[1] = CFG_DATA_BITS'(h);
        v[2] = CFG_DATA_BITS'(r);
        v[3] = CFG_DATA_BITS'(f);
        for (int i = 0; i < 4; i++) begin
            if (sel[i]) begin
                i_cfg_we   <= 1'b1;
                i_cfg_idx  <= t_reg_idx'(i);
                i_cfg_data <= v[i];
                @(posedge i_clk);
                case (t_reg_idx'(i))
                    REG_WIDTH:  cfg_w = v[i][CFG_W_BITS-1:0];
                    REG_HEIGHT: cfg_h = v[i][CFG_H_BITS-1:0];
                    REG_RADIUS: cfg_r = v[i][CFG_R_BITS-1:0];
                    REG_WEIGHT: cfg_f = v[i][CFG_F_BITS-1:0];
                    default: ;
                endcase
                in_col = 0; in_row = 0; out_col = 0; out_row = 0; in_done = 1'b0;
            end
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [PIX_BITS-1:0] rand_pixel();
        case ($urandom_range(0, 11))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return '0;
            3: return '1;
            default: return PIX_BITS'($urandom);
        endcase
    endfunction

    // feed npix pixels with stray fillers, then flush the frame if it is complete
    task automatic run_frame(input int unsigned npix);
        for (int unsigned i = 0; i < npix; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_word(rand_pixel(), 1'($urandom_range(0, 1)), 1'b1);
            send_word(rand_pixel(), ($urandom_range(0, 5) == 0), 1'b0);
        end
        while (in_done) begin
            if ($urandom_range(0, 3) == 0)
                send_word(rand_pixel(), 1'($urandom_range(0, 1)), 1'b0);
            else send_word(rand_pixel(), 1'($urandom_range(0, 1)), 1'b1);
        end
    endtask

    // receiver: check each word, random stalls, one long hold-off on request
    initial begin
        int stall;
        t_blur_res want;
        stall = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                if (blurred_q.size() == 0) report_mismatch("result with nothing expected");
                else begin
                    want = blurred_q.pop_front();
                    if (out_if.blurred_value !== want.val)
                        report_mismatch($sformatf("blurred_value %0d, want %0d",
                                                  out_if.blurred_value, want.val));
                    if (out_if.last_pixel !== want.last)
                        report_mismatch($sformatf("last_pixel %0b, want %0b",
                                                  out_if.last_pixel, want.last));
                end
            end
            if (hold_cycles > 0) begin
                out_if.ready <= 1'b0;
                hold_cycles--;
            end else if (stall > 0) begin
                out_if.ready <= 1'b0;
                stall--;
            end else begin
                out_if.ready <= 1'b1;
                if (!calm) stall = pick_gap();
            end
        end
    end

    initial begin
        int unsigned total;
        bit pressed;
        t_dir_row row;
        n_errors = 0;
        n_sent = 0;
        hold_cycles = 0;
        calm = 1'b0;
        pressed = 1'b0;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= REG_WIDTH;
        i_cfg_data        <= '0;
        in_if.valid       <= 1'b0;
        in_if.pixel_value <= '0;
        in_if.hot_flag    <= 1'b0;
        in_if.flush_tick  <= 1'b0;
        cfg_w = RST_WIDTH;
        cfg_h = RST_HEIGHT;
        cfg_r = RST_RADIUS;
        cfg_f = RST_WEIGHT;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0; in_done = 1'b0;

        dir_tab = '{
            // one pixel frame: the result is the pixel itself, or zero when hot
            '{1, 0, 0, 0, 256, 0, 0, 0},
            '{0, 32767, 0, 0, 0, 1, 32767, 1},
            '{0, -32768, 0, 0, 0, 1, -32768, 1},
            '{0, 0, 0, 0, 0, 1, 0, 1},
            '{0, 1234, 1, 0, 0, 1, 0, 1},
            '{0, 77, 0, 1, 0, 0, 0, 0},
            // radius wider than the frame, zero weight, filler inside the frame
            '{1, 2, 2, 7, 0, 0, 0, 0},
            '{0, 100, 0, 0, 0, 0, 0, 0},
            '{0, -5, 1, 0, 0, 0, 0, 0},
            '{0, 9, 0, 1, 0, 0, 0, 0},
            '{0, -32768, 0, 0, 0, 0, 0, 0},
            '{0, 32767, 0, 0, 0, 0, 0, 0},
            '{0, 0, 0, 1, 0, 0, 0, 0},
            '{0, 0, 0, 1, 0, 0, 0, 0},
            '{0, 55, 1, 0, 0, 0, 0, 0},
            // weight above one, saturating sums, pixel after frame end flushes
            '{1, 2, 3, 1, 511, 0, 0, 0},
            '{0, 32767, 0, 0, 0, 0, 0, 0},
            '{0, 32767, 0, 0, 0, 0, 0, 0},
            '{0, -32768, 0, 0, 0, 0, 0, 0},
            '{0, 32767, 1, 0, 0, 0, 0, 0},
            '{0, 32767, 0, 0, 0, 0, 0, 0},
            '{0, -1, 0, 0, 0, 0, 0, 0},
            '{0, 0, 0, 1, 0, 0, 0, 0},
            '{0, 3, 0, 0, 0, 0, 0, 0},
            '{0, 0, 0, 1, 0, 0, 0, 0}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            row = dir_tab[i];
            if (row.is_cfg) begin
                wait_idle();
                load_regs(4'hF, row.a, row.b, row.c, row.d);
            end else begin
                total = blurred_q.size();
                send_word(row.a[PIX_BITS-1:0], row.b[0], row.c[0]);
                if (row.has_exp && blurred_q.size() > total) begin
                    blurred_q[$].val  = row.exp_val[PIX_BITS-1:0];
                    blurred_q[$].last = row.exp_last;
                end
            end
        end

        // widest row and tallest column, both beyond range, start of frame only
        wait_idle();
        load_regs(4'hF, 2047, 8191, 0, 511);
        run_frame(40);
        wait_idle();
        load_regs(4'hF, 1, 8191, 7, 0);
        run_frame(60);

        while (n_sent < 650) begin
            wait_idle();
            calm = ($urandom_range(0, 3) == 0);
            load_regs((4'b1 << $urandom_range(0, 3)) | 4'($urandom_range(0, 15)),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12),
                      $urandom_range(1, 8),
                      ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2),
                      $urandom_range(0, 511));
            total = eff_w() * eff_h();
            if (!pressed && n_sent > 450) begin
                hold_cycles = 3000;
                pressed = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) run_frame($urandom_range(1, total));
            else run_frame(total);
        end
        calm = 1'b0;

        in_if.valid <= 1'b0;
        while (blurred_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/mwbb_pkg.sv
rtl/mwbb_in_if.sv
rtl/mwbb_out_if.sv
rtl/mwbb_ram.sv
rtl/masked_weighted_box_blur.sv
test/masked_weighted_box_blur_tb.sv
